/* hdl/rbi_pkg.sv */
// ----------------------------------------------------------------------------
// rbi_pkg: shared types and constants for the ray / box intersection pipe
// Word widths, fixed-point format, per-item payload and result structures.
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = DATA_W + FRAC_BITS;  // quotient bits, one per divider stage
    localparam int NUM_AXES  = 3;
    localparam int PROD_W    = 2 * DATA_W;

    typedef logic [DATA_W-1:0]                t_word;
    typedef logic [NUM_AXES-1:0][DATA_W-1:0]  t_vec3;
    typedef logic [1:0]                       t_axis;

    localparam t_word S_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_word S_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    // -1.0 in the fixed-point format: distance of an axis that offers no plane
    localparam t_word T_NONE = t_word'(-(longint'(1) <<< FRAC_BITS));

    typedef struct packed {
        t_vec3               org;
        t_vec3               dir;
        t_vec3               bmin;
        t_vec3               bmax;
        t_vec3               plane;
        logic [NUM_AXES-1:0] do_div;
        logic [NUM_AXES-1:0] neg;
        logic                org_in;
    } t_item;

    typedef struct packed {
        t_vec3 num;
        t_vec3 den;
    } t_div_op;

    typedef struct packed {
        t_word tb;
        t_axis best;
        logic  miss;
        logic  sat;
    } t_sel;

    typedef struct packed {
        logic  hit;
        logic  starts_inside;
        t_vec3 pt;
        logic  saturated;
    } t_result;

endpackage

/* hdl/rbi_in_if.sv */
// ----------------------------------------------------------------------------
// rbi_in_if: ray / box word channel
// Valid-ready channel carrying origin, direction and box corners.
// ----------------------------------------------------------------------------
interface rbi_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rbi_pkg::DATA_W-1:0] origin_x;
    logic signed [rbi_pkg::DATA_W-1:0] origin_y;
    logic signed [rbi_pkg::DATA_W-1:0] origin_z;
    logic signed [rbi_pkg::DATA_W-1:0] dir_x;
    logic signed [rbi_pkg::DATA_W-1:0] dir_y;
    logic signed [rbi_pkg::DATA_W-1:0] dir_z;
    logic signed [rbi_pkg::DATA_W-1:0] box_min_x;
    logic signed [rbi_pkg::DATA_W-1:0] box_min_y;
    logic signed [rbi_pkg::DATA_W-1:0] box_min_z;
    logic signed [rbi_pkg::DATA_W-1:0] box_max_x;
    logic signed [rbi_pkg::DATA_W-1:0] box_max_y;
    logic signed [rbi_pkg::DATA_W-1:0] box_max_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    output ready);
endinterface

/* hdl/rbi_out_if.sv */
// ----------------------------------------------------------------------------
// rbi_out_if: intersection result word channel
// Valid-ready channel carrying hit flags, hit point and saturation flag.
// ----------------------------------------------------------------------------
interface rbi_out_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic                              starts_inside;
    logic signed [rbi_pkg::DATA_W-1:0] hit_x;
    logic signed [rbi_pkg::DATA_W-1:0] hit_y;
    logic signed [rbi_pkg::DATA_W-1:0] hit_z;
    logic                              saturated;

    modport source (output valid, hit, starts_inside, hit_x, hit_y, hit_z, saturated,
                    input ready);
    modport sink   (input valid, hit, starts_inside, hit_x, hit_y, hit_z, saturated,
                    output ready);
endinterface

/* hdl/rbi_classify.sv */
// ----------------------------------------------------------------------------
// rbi_classify: slab classification stage
// Class the origin per axis, pick the plane, form divider operands.
// ----------------------------------------------------------------------------
module rbi_classify (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rbi_pkg::t_vec3   i_org,
    input  rbi_pkg::t_vec3   i_dir,
    input  rbi_pkg::t_vec3   i_bmin,
    input  rbi_pkg::t_vec3   i_bmax,
    output logic             o_valid,
    output rbi_pkg::t_item   o_item,
    output rbi_pkg::t_div_op o_op
);

    logic             r_valid;
    rbi_pkg::t_item   r_item, n_item;
    rbi_pkg::t_div_op r_op, n_op;

    always_comb begin
        logic below, above;
        logic [rbi_pkg::DATA_W:0] diff;
        n_item        = '0;
        n_op          = '0;
        n_item.org    = i_org;
        n_item.dir    = i_dir;
        n_item.bmin   = i_bmin;
        n_item.bmax   = i_bmax;
        n_item.org_in = 1'b1;
        for (int a = 0; a < rbi_pkg::NUM_AXES; a++) begin
            below = $signed(i_org[a]) < $signed(i_bmin[a]);
            above = $signed(i_org[a]) > $signed(i_bmax[a]);
            if (below) begin
                n_item.plane[a] = i_bmin[a];
            end else if (above) begin
                n_item.plane[a] = i_bmax[a];
            end else begin
                n_item.plane[a] = '0;
            end
            if (below || above) begin
                n_item.org_in = 1'b0;
            end
            n_item.do_div[a] = (below || above) && (i_dir[a] != '0);
            diff = {n_item.plane[a][rbi_pkg::DATA_W-1], n_item.plane[a]}
                 - {i_org[a][rbi_pkg::DATA_W-1], i_org[a]};
            n_item.neg[a] = diff[rbi_pkg::DATA_W] ^ i_dir[a][rbi_pkg::DATA_W-1];
            // magnitudes fit the word: at most 2^32-1 and 2^31
            n_op.num[a] = diff[rbi_pkg::DATA_W] ? rbi_pkg::DATA_W'(-diff)
                                                : diff[rbi_pkg::DATA_W-1:0];
            n_op.den[a] = i_dir[a][rbi_pkg::DATA_W-1] ? -i_dir[a] : i_dir[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_op   <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_op    = r_op;

endmodule

/* hdl/rbi_divider.sv */
// ----------------------------------------------------------------------------
// rbi_divider: pipelined restoring divider
// Unsigned (num << FRAC_BITS) / den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rbi_divider (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  rbi_pkg::t_word             i_num,
    input  rbi_pkg::t_word             i_den,
    output logic [rbi_pkg::DIV_W-1:0]  o_quo
);

    rbi_pkg::t_word             r_rem [rbi_pkg::DIV_W];
    rbi_pkg::t_word             n_rem [rbi_pkg::DIV_W];
    rbi_pkg::t_word             r_den [rbi_pkg::DIV_W];
    rbi_pkg::t_word             n_den [rbi_pkg::DIV_W];
    logic [rbi_pkg::DIV_W-1:0]  r_dvd [rbi_pkg::DIV_W];
    logic [rbi_pkg::DIV_W-1:0]  n_dvd [rbi_pkg::DIV_W];
    logic [rbi_pkg::DIV_W-1:0]  r_quo [rbi_pkg::DIV_W];
    logic [rbi_pkg::DIV_W-1:0]  n_quo [rbi_pkg::DIV_W];

    always_comb begin
        rbi_pkg::t_word            s_rem, s_den;
        logic [rbi_pkg::DIV_W-1:0] s_dvd, s_quo;
        logic [rbi_pkg::DATA_W:0]  trial, diff;
        for (int k = 0; k < rbi_pkg::DIV_W; k++) begin
            if (k == 0) begin
                s_rem = '0;
                s_den = i_den;
                s_dvd = {i_num, {rbi_pkg::FRAC_BITS{1'b0}}};
                s_quo = '0;
            end else begin
                s_rem = r_rem[k-1];
                s_den = r_den[k-1];
                s_dvd = r_dvd[k-1];
                s_quo = r_quo[k-1];
            end
            // remainder stays below den, so the trial fits one extra bit
            trial = {s_rem, s_dvd[rbi_pkg::DIV_W-1]};
            diff  = trial - {1'b0, s_den};
            if (trial >= {1'b0, s_den}) begin
                n_rem[k] = diff[rbi_pkg::DATA_W-1:0];
                n_quo[k] = {s_quo[rbi_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[rbi_pkg::DATA_W-1:0];
                n_quo[k] = {s_quo[rbi_pkg::DIV_W-2:0], 1'b0};
            end
            n_dvd[k] = s_dvd << 1;
            n_den[k] = s_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_dvd <= n_dvd;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo[rbi_pkg::DIV_W-1];

endmodule

/* hdl/rbi_hitpoint.sv */
// ----------------------------------------------------------------------------
// rbi_hitpoint: hit point and box test stages
// Multiply, shift/clamp/add, then range check and result formatting.
// ----------------------------------------------------------------------------
module rbi_hitpoint (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rbi_pkg::t_item   i_item,
    input  rbi_pkg::t_sel    i_sel,
    output logic             o_valid,
    output rbi_pkg::t_result o_res
);

    // multiply stage
    logic                                   r_m_valid;
    rbi_pkg::t_item                         r_m_item;
    rbi_pkg::t_sel                          r_m_sel;
    logic signed [rbi_pkg::PROD_W-1:0]      r_m_prod [rbi_pkg::NUM_AXES];
    // add stage
    logic                                   r_a_valid;
    rbi_pkg::t_item                         r_a_item;
    rbi_pkg::t_sel                          r_a_sel;
    rbi_pkg::t_vec3                         r_a_pt, n_a_pt;
    logic                                   r_a_psat, n_a_psat;
    // result stage
    logic                                   r_valid;
    rbi_pkg::t_result                       r_res, n_res;

    always_comb begin
        logic signed [rbi_pkg::PROD_W-1:0] shp;
        rbi_pkg::t_word                    m;
        logic [rbi_pkg::DATA_W:0]          sum;
        n_a_psat = 1'b0;
        n_a_pt   = '0;
        for (int a = 0; a < rbi_pkg::NUM_AXES; a++) begin
            shp = r_m_prod[a] >>> rbi_pkg::FRAC_BITS;
            if (shp > $signed({{rbi_pkg::DATA_W{1'b0}}, rbi_pkg::S_MAX})) begin
                m = rbi_pkg::S_MAX;
                n_a_psat = n_a_psat | (r_m_sel.best != rbi_pkg::t_axis'(a));
            end else if (shp < $signed({{rbi_pkg::DATA_W{1'b1}}, rbi_pkg::S_MIN})) begin
                m = rbi_pkg::S_MIN;
                n_a_psat = n_a_psat | (r_m_sel.best != rbi_pkg::t_axis'(a));
            end else begin
                m = shp[rbi_pkg::DATA_W-1:0];
            end
            sum = {m[rbi_pkg::DATA_W-1], m}
                + {r_m_item.org[a][rbi_pkg::DATA_W-1], r_m_item.org[a]};
            if (r_m_sel.best == rbi_pkg::t_axis'(a)) begin
                n_a_pt[a] = r_m_item.plane[a];
            end else if (sum[rbi_pkg::DATA_W] != sum[rbi_pkg::DATA_W-1]) begin
                n_a_pt[a] = sum[rbi_pkg::DATA_W] ? rbi_pkg::S_MIN : rbi_pkg::S_MAX;
                n_a_psat  = 1'b1;
            end else begin
                n_a_pt[a] = sum[rbi_pkg::DATA_W-1:0];
            end
        end
    end

    always_comb begin
        logic in_box;
        in_box = 1'b1;
        for (int a = 0; a < rbi_pkg::NUM_AXES; a++) begin
            if (r_a_sel.best != rbi_pkg::t_axis'(a) &&
                ($signed(r_a_pt[a]) < $signed(r_a_item.bmin[a]) ||
                 $signed(r_a_pt[a]) > $signed(r_a_item.bmax[a]))) begin
                in_box = 1'b0;
            end
        end
        n_res = '0;
        priority if (r_a_item.org_in) begin
            n_res.hit           = 1'b1;
            n_res.starts_inside = 1'b1;
            n_res.pt            = r_a_item.org;
        end else if (r_a_sel.miss) begin
            n_res.saturated = r_a_sel.sat;
        end else begin
            n_res.hit       = in_box;
            n_res.pt        = in_box ? r_a_pt : '0;
            n_res.saturated = r_a_sel.sat | r_a_psat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
            r_a_valid <= r_m_valid;
            r_valid   <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_item <= i_item;
            r_m_sel  <= i_sel;
            for (int a = 0; a < rbi_pkg::NUM_AXES; a++) begin
                r_m_prod[a] <= $signed(i_sel.tb) * $signed(i_item.dir[a]);
            end
            r_a_item <= r_m_item;
            r_a_sel  <= r_m_sel;
            r_a_pt   <= n_a_pt;
            r_a_psat <= n_a_psat;
            r_res    <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hdl/ray_box_intersect.sv */
// ----------------------------------------------------------------------------
// ray_box_intersect: pipelined ray / axis-aligned box intersection
// Woo's slab test in signed fixed point with saturating divide and multiply.
// ----------------------------------------------------------------------------
// Stages in Q16.16: classify, divider, clamp, select, multiply, add and result.
// Throughput: one word per cycle when not stalled; bit-per-stage dividers set depth.
// Stall: one enable holds every stage while the result word waits, so nothing
// is lost or repeated; ready is high whenever the output register is free.
// Reset: synchronous active-low clears all stage valid bits; data is not reset.
module ray_box_intersect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbi_in_if.sink     i_ray,
    rbi_out_if.source  o_res
);

    // global advance: move every stage when the output slot frees up
    logic             w_en;
    logic             w_out_valid;
    rbi_pkg::t_result w_res;

    rbi_pkg::t_vec3   w_org, w_dir, w_bmin, w_bmax;
    logic             w_cls_valid;
    rbi_pkg::t_item   w_cls_item;
    rbi_pkg::t_div_op w_cls_op;

    logic [rbi_pkg::DIV_W-1:0] w_quo [rbi_pkg::NUM_AXES];

    // payload delay line matched to the divider depth
    logic             r_dl_valid [rbi_pkg::DIV_W];
    rbi_pkg::t_item   r_dl_item  [rbi_pkg::DIV_W];

    // clamp stage
    logic             r_c_valid;
    rbi_pkg::t_item   r_c_item;
    rbi_pkg::t_vec3   r_c_t, n_c_t;
    logic             r_c_sat, n_c_sat;

    // select stage
    logic             r_s_valid;
    rbi_pkg::t_item   r_s_item;
    rbi_pkg::t_sel    r_s_sel, n_s_sel;

    assign w_en        = !w_out_valid || o_res.ready;
    assign i_ray.ready = w_en;

    assign w_org  = {i_ray.origin_z,  i_ray.origin_y,  i_ray.origin_x};
    assign w_dir  = {i_ray.dir_z,     i_ray.dir_y,     i_ray.dir_x};
    assign w_bmin = {i_ray.box_min_z, i_ray.box_min_y, i_ray.box_min_x};
    assign w_bmax = {i_ray.box_max_z, i_ray.box_max_y, i_ray.box_max_x};

    rbi_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_ray.valid),
        .i_org   (w_org),
        .i_dir   (w_dir),
        .i_bmin  (w_bmin),
        .i_bmax  (w_bmax),
        .o_valid (w_cls_valid),
        .o_item  (w_cls_item),
        .o_op    (w_cls_op)
    );

    // one divider per axis, all three run in lockstep
    for (genvar a = 0; a < rbi_pkg::NUM_AXES; a++) begin : g_div
        rbi_divider u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_cls_op.num[a]),
            .i_den (w_cls_op.den[a]),
            .o_quo (w_quo[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rbi_pkg::DIV_W; k++) begin
                r_dl_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dl_valid[0] <= w_cls_valid;
            for (int k = 1; k < rbi_pkg::DIV_W; k++) begin
                r_dl_valid[k] <= r_dl_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_item[0] <= w_cls_item;
            for (int k = 1; k < rbi_pkg::DIV_W; k++) begin
                r_dl_item[k] <= r_dl_item[k-1];
            end
        end
    end

    // clamp quotients to the signed word; axes with no plane take -1.0
    always_comb begin
        rbi_pkg::t_item it;
        logic           big;
        it      = r_dl_item[rbi_pkg::DIV_W-1];
        n_c_sat = 1'b0;
        n_c_t   = '0;
        for (int a = 0; a < rbi_pkg::NUM_AXES; a++) begin
            // quotient at least 2^31
            big = |w_quo[a][rbi_pkg::DIV_W-1:rbi_pkg::DATA_W-1];
            if (!it.do_div[a]) begin
                n_c_t[a] = rbi_pkg::T_NONE;
            end else if (it.neg[a]) begin
                if (|w_quo[a][rbi_pkg::DIV_W-1:rbi_pkg::DATA_W] ||
                    (w_quo[a][rbi_pkg::DATA_W-1] && |w_quo[a][rbi_pkg::DATA_W-2:0])) begin
                    n_c_t[a] = rbi_pkg::S_MIN;
                    n_c_sat  = 1'b1;
                end else begin
                    n_c_t[a] = -w_quo[a][rbi_pkg::DATA_W-1:0];
                end
            end else if (big) begin
                n_c_t[a] = rbi_pkg::S_MAX;
                n_c_sat  = 1'b1;
            end else begin
                n_c_t[a] = w_quo[a][rbi_pkg::DATA_W-1:0];
            end
        end
    end

    // pick the largest distance, lowest axis on ties
    always_comb begin
        n_s_sel      = '0;
        n_s_sel.tb   = r_c_t[0];
        n_s_sel.best = rbi_pkg::t_axis'(0);
        for (int a = 1; a < rbi_pkg::NUM_AXES; a++) begin
            if ($signed(n_s_sel.tb) < $signed(r_c_t[a])) begin
                n_s_sel.tb   = r_c_t[a];
                n_s_sel.best = rbi_pkg::t_axis'(a);
            end
        end
        n_s_sel.miss = n_s_sel.tb[rbi_pkg::DATA_W-1];
        n_s_sel.sat  = r_c_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_dl_valid[rbi_pkg::DIV_W-1];
            r_s_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_item <= r_dl_item[rbi_pkg::DIV_W-1];
            r_c_t    <= n_c_t;
            r_c_sat  <= n_c_sat;
            r_s_item <= r_c_item;
            r_s_sel  <= n_s_sel;
        end
    end

    rbi_hitpoint u_hitpoint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s_valid),
        .i_item  (r_s_item),
        .i_sel   (r_s_sel),
        .o_valid (w_out_valid),
        .o_res   (w_res)
    );

    assign o_res.valid         = w_out_valid;
    assign o_res.hit           = w_res.hit;
    assign o_res.starts_inside = w_res.starts_inside;
    assign o_res.hit_x         = w_res.pt[0];
    assign o_res.hit_y         = w_res.pt[1];
    assign o_res.hit_z         = w_res.pt[2];
    assign o_res.saturated     = w_res.saturated;

    // an origin inside the box is always a clean hit
    a_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.starts_inside |-> o_res.hit && !o_res.saturated)
        else $error("inside origin without clean hit");

    // a miss reports a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.hit_x == '0 && o_res.hit_y == '0 &&
                                      o_res.hit_z == '0)
        else $error("miss with nonzero point");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid && !r_s_valid && !r_c_valid)
        else $error("valid survived reset");

    // a distance flagged as no-plane never wins a hit
    a_sel_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && !r_s_item.org_in && r_s_sel.tb == rbi_pkg::T_NONE |-> r_s_sel.miss)
        else $error("negative distance accepted");

endmodule

/* dv/tb_ray_box_intersect.sv */
// ----------------------------------------------------------------------------
// tb_ray_box_intersect: self-checking bench for the ray / box intersection pipe
// Streams directed and random rays through the block, predicts each result in
// fixed point and compares it field by field, both sides idling in two phases.
// ----------------------------------------------------------------------------
module tb_ray_box_intersect;

    typedef struct {
        longint org[3];
        longint dir[3];
        longint bmin[3];
        longint bmax[3];
    } t_ray;

    typedef struct {
        bit     hit;
        bit     starts_inside;
        longint pt[3];
        bit     saturated;
    } t_hit_res;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = rbi_pkg::DIV_W + 20;

    logic i_clk;
    logic i_rst_n;

    rbi_in_if  ray_if ();
    rbi_out_if res_if ();

    ray_box_intersect i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_if.sink),
        .o_res   (res_if.source)
    );

    t_ray     ray_queue[$];
    t_hit_res expected_hits[$];
    int       error_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       idle_cycles;
    bit       stimulus_done;
    bit       in_taken;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Clamp to the signed 32-bit range, raising the saturation flag.
    function automatic longint clamp_s32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // (num << FRAC_BITS) / den, truncated toward zero, saturated.
    function automatic longint fixed_div(longint num, longint den, inout bit sat);
        bit              neg;
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n << rbi_pkg::FRAC_BITS) / d;
        if (neg) begin
            if (q > 64'd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(q);
    endfunction

    // (t * d) >> FRAC_BITS rounded toward minus infinity, saturated.
    function automatic longint fixed_mul(longint t, longint d, inout bit sat);
        return clamp_s32(((t * d) >>> rbi_pkg::FRAC_BITS), sat);
    endfunction

    function automatic t_hit_res slab_intersect(t_ray r);
        t_hit_res res;
        longint   plane[3];
        longint   tdist[3];
        longint   pt[3];
        longint   m;
        int       cls[3];
        bit       org_in;
        bit       sat;
        bit       hit;
        int       best;
        org_in = 1'b1;
        sat    = 1'b0;
        hit    = 1'b1;
        res.hit = 0;
        res.starts_inside = 0;
        res.saturated = 0;
        for (int a = 0; a < 3; a++) begin
            res.pt[a] = 0;
            plane[a] = 0;
            cls[a] = 0;
            if (r.org[a] < r.bmin[a]) begin
                cls[a] = 1;
                plane[a] = r.bmin[a];
                org_in = 1'b0;
            end else if (r.org[a] > r.bmax[a]) begin
                cls[a] = 2;
                plane[a] = r.bmax[a];
                org_in = 1'b0;
            end
        end
        if (org_in) begin
            res.hit = 1;
            res.starts_inside = 1;
            for (int a = 0; a < 3; a++) res.pt[a] = r.org[a];
            return res;
        end
        for (int a = 0; a < 3; a++) begin
            if (cls[a] != 0 && r.dir[a] != 0)
                tdist[a] = fixed_div(plane[a] - r.org[a], r.dir[a], sat);
            else
                tdist[a] = -(64'sd1 << rbi_pkg::FRAC_BITS);
        end
        best = 0;
        for (int a = 1; a < 3; a++)
            if (tdist[best] < tdist[a]) best = a;
        if (tdist[best] < 0) begin
            res.saturated = sat;
            return res;
        end
        for (int a = 0; a < 3; a++) begin
            if (a == best) begin
                pt[a] = plane[a];
            end else begin
                m = fixed_mul(tdist[best], r.dir[a], sat);
                pt[a] = clamp_s32(r.org[a] + m, sat);
                if (pt[a] < r.bmin[a] || pt[a] > r.bmax[a]) hit = 1'b0;
            end
        end
        if (hit) begin
            res.hit = 1;
            for (int a = 0; a < 3; a++) res.pt[a] = pt[a];
        end
        res.saturated = sat;
        return res;
    endfunction

    function automatic longint rand_s32();
        int unsigned v;
        v = $urandom;
        return longint'(int'(v));
    endfunction

    // Pick a coordinate: mostly small, sometimes an extreme, sometimes fully random.
    function automatic longint rand_coord();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return longint'($urandom_range(0, 40 << rbi_pkg::FRAC_BITS))
                   - (20 << rbi_pkg::FRAC_BITS);
        if (sel == 6) return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
        if (sel == 7) return longint'($urandom_range(0, 6)) - 3;
        return rand_s32();
    endfunction

    // Well-formed ray aimed near a proper box, or plain noise.
    function automatic t_ray rand_ray();
        t_ray   r;
        longint c;
        longint w;
        bit     noise;
        noise = ($urandom_range(0, 9) == 0);
        for (int a = 0; a < 3; a++) begin
            if (noise) begin
                r.org[a] = rand_s32();
                r.dir[a] = rand_s32();
                r.bmin[a] = rand_s32();
                r.bmax[a] = rand_s32();
            end else begin
                c = rand_coord();
                w = $urandom_range(0, 8 << rbi_pkg::FRAC_BITS);
                r.bmin[a] = c;
                r.bmax[a] = (c + w > 64'sd2147483647) ? 64'sd2147483647 : c + w;
                r.org[a] = rand_coord();
                r.dir[a] = ($urandom_range(0, 7) == 0) ? 0 : rand_coord();
                // Aim the direction back toward the box most of the time.
                if ($urandom_range(0, 3) != 0)
                    r.dir[a] = (r.org[a] > c) ? -(r.dir[a] < 0 ? -r.dir[a] : r.dir[a])
                                              : (r.dir[a] < 0 ? -r.dir[a] : r.dir[a]);
                if (r.dir[a] > 64'sd2147483647) r.dir[a] = 64'sd2147483647;
            end
        end
        return r;
    endfunction

    function automatic t_ray make_ray(longint ox, longint oy, longint oz,
                                      longint dx, longint dy, longint dz,
                                      longint lo, longint hi);
        t_ray r;
        r.org = '{ox, oy, oz};
        r.dir = '{dx, dy, dz};
        r.bmin = '{lo, lo, lo};
        r.bmax = '{hi, hi, hi};
        return r;
    endfunction

    // Note whether the word on the input was taken at this edge.
    always @(posedge i_clk) begin
        in_taken <= ray_if.valid && ray_if.ready;
    end

    // Driver: advance to the next queued word once the current one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            ray_if.valid <= 1'b0;
        end else if (!ray_if.valid || in_taken) begin
            if (ray_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_ray r;
                r = ray_queue.pop_front();
                expected_hits.push_back(slab_intersect(r));
                ray_if.valid     <= 1'b1;
                ray_if.origin_x  <= r.org[0];
                ray_if.origin_y  <= r.org[1];
                ray_if.origin_z  <= r.org[2];
                ray_if.dir_x     <= r.dir[0];
                ray_if.dir_y     <= r.dir[1];
                ray_if.dir_z     <= r.dir[2];
                ray_if.box_min_x <= r.bmin[0];
                ray_if.box_min_y <= r.bmin[1];
                ray_if.box_min_z <= r.bmin[2];
                ray_if.box_max_x <= r.bmax[0];
                ray_if.box_max_y <= r.bmax[1];
                ray_if.box_max_z <= r.bmax[2];
            end else begin
                ray_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random.
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((ray_if.valid && ray_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_if.valid && res_if.ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result word hit=%0b", $time, res_if.hit);
                    error_count <= error_count + 1;
                end else begin
                    t_hit_res e;
                    e = expected_hits.pop_front();
                    if (res_if.hit !== e.hit || res_if.starts_inside !== e.starts_inside
                        || res_if.hit_x !== 32'(e.pt[0]) || res_if.hit_y !== 32'(e.pt[1])
                        || res_if.hit_z !== 32'(e.pt[2]) || res_if.saturated !== e.saturated)
                    begin
                        $display("%0t: expected hit=%0b in=%0b pt=%h,%h,%h sat=%0b", $time,
                                 e.hit, e.starts_inside, 32'(e.pt[0]), 32'(e.pt[1]),
                                 32'(e.pt[2]), e.saturated);
                        $display("%0t: actual   hit=%0b in=%0b pt=%h,%h,%h sat=%0b", $time,
                                 res_if.hit, res_if.starts_inside, res_if.hit_x,
                                 res_if.hit_y, res_if.hit_z, res_if.saturated);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_ray_box_intersect failed");
                $finish;
            end
        end
    end

    initial begin
        longint one;
        longint mx;
        longint mn;
        one = 64'sd1 << rbi_pkg::FRAC_BITS;
        mx  = 64'sd2147483647;
        mn  = -64'sd2147483648;
        error_count   = 0;
        idle_cycles   = 0;
        stimulus_done = 0;
        send_idle_pct = 10;
        recv_idle_pct = 45;
        i_rst_n = 1'b0;
        ray_if.valid = 1'b0;
        {ray_if.origin_x, ray_if.origin_y, ray_if.origin_z} = '0;
        {ray_if.dir_x, ray_if.dir_y, ray_if.dir_z} = '0;
        {ray_if.box_min_x, ray_if.box_min_y, ray_if.box_min_z} = '0;
        {ray_if.box_max_x, ray_if.box_max_y, ray_if.box_max_z} = '0;
        res_if.ready = 1'b0;

        // Directed: inside, four faces, ties, zero distance, degenerate box, extremes.
        ray_queue.push_back(make_ray(0, 0, 0, one, one, one, -one, one));
        ray_queue.push_back(make_ray(-4*one, 0, 0, one, 0, 0, -one, one));
        ray_queue.push_back(make_ray(4*one, 0, 0, -one, 0, 0, -one, one));
        ray_queue.push_back(make_ray(0, -4*one, 0, 0, one, 0, -one, one));
        ray_queue.push_back(make_ray(0, 0, 4*one, 0, 0, -one, -one, one));
        ray_queue.push_back(make_ray(-4*one, -4*one, -4*one, one, one, one, -one, one));
        ray_queue.push_back(make_ray(-one, 0, 0, one, 0, 0, -one, one));
        ray_queue.push_back(make_ray(-4*one, 0, 0, -one, 0, 0, -one, one));
        ray_queue.push_back(make_ray(-4*one, 0, 0, 0, 0, 0, -one, one));
        ray_queue.push_back(make_ray(-4*one, 3*one, 0, one, 0, 0, -one, one));
        ray_queue.push_back(make_ray(0, 0, 0, one, 0, 0, one, -one));
        ray_queue.push_back(make_ray(mn, mn, mn, 1, 1, 1, mx, mx));
        ray_queue.push_back(make_ray(mx, mx, mx, mn, mn, mn, mn, mn));
        ray_queue.push_back(make_ray(mn, 0, 0, 1, mx, mn, mx, mx));
        ray_queue.push_back(make_ray(mx, mn, mx, -1, -1, -1, mn, mn + 1));
        ray_queue.push_back(make_ray(mn, mx, mn, mx, mn, mx, -one, one));
        ray_queue.push_back(make_ray(-1, -1, -1, -1, -1, -1, 0, 0));
        ray_queue.push_back(make_ray(-4*one, 0, 0, one, 3, -3, -one, one));
        ray_queue.push_back(make_ray(mn, mn, 0, mx, -1, 1, mx, mx));
        ray_queue.push_back(make_ray(mx, mx, mx, mx, mx, mx, mn, mx - 1));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 10 : 0;
            for (int n = 0; n < 450; n++) ray_queue.push_back(rand_ray());
            while (ray_queue.size() > 0 || expected_hits.size() > 0) @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_hits.size() == 0)
            $display("tb_ray_box_intersect passed");
        else
            $display("tb_ray_box_intersect failed");
        $finish;
    end
endmodule
